/* design/derivation_path_junction_parser_defines.svh */
`ifndef DERIVATION_PATH_JUNCTION_PARSER_DEFINES_SVH
`define DERIVATION_PATH_JUNCTION_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DPJP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPJP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dpjp_pkg.sv */
package dpjp_pkg;

    localparam int MAX_PATH_BYTES = 128;
    localparam int MAX_JUNCTIONS  = 8;

    localparam int CODE_BYTES  = 32;
    localparam int STORE_DEPTH = CODE_BYTES - 1;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(CODE_BYTES) + 1;
    localparam int CODE_W      = 8 * CODE_BYTES;
    localparam int STORE_W     = 8 * STORE_DEPTH;
    localparam int WORD_W      = 64;

    localparam logic [7:0] SLASH = 8'h2F;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    typedef struct packed {
        logic              has_words;
        logic              has_status;
        logic [2:0]        jidx;
        logic              hard;
        logic              status;
        logic [3:0]        count;
        logic [CODE_W-1:0] code;
    } t_job;

    function automatic logic [CODE_W-1:0] f_chain_code(
        input logic [STORE_W-1:0] jb,
        input logic [LEN_W-1:0]   len
    );
        logic [CODE_W-1:0] c;
        c = '0;
        if (len < LEN_W'(CODE_BYTES)) begin
            c[7:0] = 8'({len, 2'b00});
            for (int p = 1; p < CODE_BYTES; p++) begin
                if (LEN_W'(p) <= len) begin
                    c[8*p +: 8] = jb[8*(p-1) +: 8];
                end
            end
        end
        return c;
    endfunction

endpackage

/* design/dpjp_parser.sv */
module dpjp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_path_byte,
    input  logic [9:0]          i_path_len,
    output dpjp_pkg::t_job      o_job
);

    typedef enum logic [1:0] {
        PH_EXPECT,
        PH_SLASHES,
        PH_JUNCTION,
        PH_STOPPED
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [9:0]                   r_bytes_seen;
    logic [1:0]                   r_slash_run, n_slash_run;
    logic [3:0]                   r_done;
    logic [dpjp_pkg::LEN_W-1:0]   r_jlen;
    logic [7:0]                   r_jb [dpjp_pkg::STORE_DEPTH];

    logic                         is_end, bad, is_slash;
    logic                         start, append, fin_slash, open_j, fin_end, fin;
    logic                         wr_en;
    logic [dpjp_pkg::STORE_AW-1:0] wa;
    logic [dpjp_pkg::LEN_W-1:0]   upd_len, fin_len;
    logic [3:0]                   done_fin, done_all;
    logic [dpjp_pkg::STORE_W-1:0] jb_flat;

    assign is_end   = (11'(r_bytes_seen) + 11'd1) >= 11'(i_path_len);
    assign bad      = (i_path_len == 10'd0) || (i_path_len > 10'(dpjp_pkg::MAX_PATH_BYTES));
    assign is_slash = (i_path_byte == dpjp_pkg::SLASH);

    always_comb begin
        n_phase     = r_phase;
        n_slash_run = r_slash_run;
        start       = 1'b0;
        append      = 1'b0;
        fin_slash   = 1'b0;
        open_j      = 1'b0;
        if (!bad) begin
            case (r_phase)
                PH_EXPECT: begin
                    if (is_slash) open_j = 1'b1;
                    else          n_phase = PH_STOPPED;
                end
                PH_SLASHES: begin
                    if (is_slash) begin
                        if (r_slash_run >= 2'd2) n_phase = PH_STOPPED;
                        else                     n_slash_run = r_slash_run + 2'd1;
                    end else begin
                        start   = 1'b1;
                        n_phase = PH_JUNCTION;
                    end
                end
                PH_JUNCTION: begin
                    if (is_slash) begin
                        fin_slash = 1'b1;
                        open_j    = 1'b1;
                    end else if (r_jlen < dpjp_pkg::LEN_W'(dpjp_pkg::CODE_BYTES)) begin
                        append = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        done_fin = r_done + 4'(fin_slash);
        if (open_j) begin
            if (done_fin >= 4'(dpjp_pkg::MAX_JUNCTIONS)) begin
                n_phase = PH_STOPPED;
            end else begin
                n_slash_run = 2'd1;
                n_phase     = PH_SLASHES;
            end
        end
    end

    always_comb begin
        if (start)       upd_len = dpjp_pkg::LEN_W'(1);
        else if (append) upd_len = r_jlen + dpjp_pkg::LEN_W'(1);
        else             upd_len = r_jlen;
        wr_en = start
            || (append && (r_jlen < dpjp_pkg::LEN_W'(dpjp_pkg::STORE_DEPTH)));
        wa    = start ? '0 : r_jlen[dpjp_pkg::STORE_AW-1:0];
        for (int i = 0; i < dpjp_pkg::STORE_DEPTH; i++) begin
            jb_flat[8*i +: 8] = (wr_en && (wa == dpjp_pkg::STORE_AW'(i)))
                ? i_path_byte : r_jb[i];
        end
    end

    assign fin_end  = is_end && !bad && (n_phase == PH_JUNCTION);
    assign fin      = fin_slash || fin_end;
    assign fin_len  = fin_slash ? r_jlen : upd_len;
    assign done_all = r_done + 4'(fin);

    always_comb begin
        o_job.has_words  = fin;
        o_job.has_status = is_end;
        o_job.jidx       = r_done[2:0];
        o_job.hard       = (r_slash_run == 2'd2);
        o_job.status     = bad ? dpjp_pkg::STATUS_BAD_LEN : dpjp_pkg::STATUS_OK;
        o_job.count      = bad ? 4'd0 : done_all;
        o_job.code       = dpjp_pkg::f_chain_code(jb_flat, fin_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_EXPECT;
            r_bytes_seen <= '0;
            r_slash_run  <= '0;
            r_done       <= '0;
            r_jlen       <= '0;
        end else if (i_accept) begin
            if (is_end) begin
                r_phase      <= PH_EXPECT;
                r_bytes_seen <= '0;
                r_slash_run  <= '0;
                r_done       <= '0;
                r_jlen       <= '0;
            end else begin
                r_phase      <= n_phase;
                r_bytes_seen <= r_bytes_seen + 10'd1;
                r_slash_run  <= n_slash_run;
                r_done       <= done_all;
                r_jlen       <= fin_slash ? '0 : upd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_jb[wa] <= i_path_byte;
        end
    end

endmodule

/* design/dpjp_emit.sv */
`include "derivation_path_junction_parser_defines.svh"

module dpjp_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  dpjp_pkg::t_job              i_job,
    input  logic                        i_out_stall,
    output logic                        o_busy,
    output logic                        o_free,
    output logic                        o_out_valid,
    output logic                        o_kind,
    output logic [2:0]                  o_junction_index,
    output logic                        o_hard_junction,
    output logic [1:0]                  o_word_index,
    output logic [dpjp_pkg::WORD_W-1:0] o_chain_word,
    output logic                        o_status,
    output logic [3:0]                  o_junction_count,
    output logic                        o_last
);

    logic           r_v;
    logic           r_stat;
    logic [1:0]     r_word;
    dpjp_pkg::t_job r_job;
    logic           xfer;

    assign o_busy      = r_v;
    assign o_out_valid = r_v;
    assign xfer        = r_v && !i_out_stall;
    assign o_free      = xfer && o_last;

    always_comb begin
        if (r_stat) begin
            o_kind           = dpjp_pkg::KIND_STATUS;
            o_junction_index = '0;
            o_hard_junction  = 1'b0;
            o_word_index     = '0;
            o_chain_word     = '0;
            o_status         = r_job.status;
            o_junction_count = r_job.count;
            o_last           = 1'b1;
        end else begin
            o_kind           = dpjp_pkg::KIND_WORD;
            o_junction_index = r_job.jidx;
            o_hard_junction  = r_job.hard;
            o_word_index     = r_word;
            o_chain_word     = r_job.code[dpjp_pkg::WORD_W*r_word +: dpjp_pkg::WORD_W];
            o_status         = dpjp_pkg::STATUS_OK;
            o_junction_count = '0;
            o_last           = (r_word == 2'd3) && !r_job.has_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_stat <= 1'b0;
            r_word <= '0;
        end else if (i_load) begin
            r_v    <= 1'b1;
            r_stat <= !i_job.has_words;
            r_word <= '0;
        end else if (xfer) begin
            if (o_last) begin
                r_v <= 1'b0;
            end else if (r_word == 2'd3) begin
                r_stat <= 1'b1;
            end else begin
                r_word <= r_word + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    `DPJP_ASSERT_NOW(a_load_only_when_free, i_clk, i_rst_n, i_load, !r_v || o_free, "job overwritten while results pending")
    `DPJP_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_v && i_out_stall, r_v && $stable(r_word) && $stable(r_stat), "result advanced under stall")
    `DPJP_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n, r_v && (o_kind == dpjp_pkg::KIND_STATUS), o_last, "status result not marked last")

endmodule

/* design/derivation_path_junction_parser.sv */
// Parses a key-derivation path arriving one byte per transfer, each byte tagged with
// the total path length. A byte that causes no result leaves the input unstalled, and a new
// byte can follow in the very next cycle. A byte that ends a junction or the path
// loads a result slot that drains one result per output transfer: four chain code
// words for a finished junction, then one status result at end of path. The next
// byte is taken in the cycle the last result leaves, so the input stalls while the
// results drain and while the output stalls.
module derivation_path_junction_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_path_byte,
    input  logic [9:0]  i_path_len,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [2:0]  o_junction_index,
    output logic        o_hard_junction,
    output logic [1:0]  o_word_index,
    output logic [63:0] o_chain_word,
    output logic        o_status,
    output logic [3:0]  o_junction_count,
    output logic        o_last
);

    dpjp_pkg::t_job job;
    logic           accept, load, busy, free;

    assign o_in_stall = busy && !free;
    assign accept     = i_in_valid && !o_in_stall;
    assign load       = accept && (job.has_words || job.has_status);

    dpjp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_path_byte (i_path_byte),
        .i_path_len  (i_path_len),
        .o_job       (job)
    );

    dpjp_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_job            (job),
        .i_out_stall      (i_out_stall),
        .o_busy           (busy),
        .o_free           (free),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_junction_index (o_junction_index),
        .o_hard_junction  (o_hard_junction),
        .o_word_index     (o_word_index),
        .o_chain_word     (o_chain_word),
        .o_status         (o_status),
        .o_junction_count (o_junction_count),
        .o_last           (o_last)
    );

endmodule
